// File: hw/rtl/fcsnf_pkg.sv
package fcsnf_pkg;

    // field widths
    localparam int VALUE_W = 51;
    localparam int MAG_W   = VALUE_W - 1;
    localparam int CHAR_W  = 7;
    localparam int DIG_W   = 4;
    localparam int DIG_N   = 15;
    localparam int BCD_W   = DIG_N * DIG_W;

    // range limits in micro-units
    localparam logic [MAG_W-1:0] HUGE_LIMIT  = 50'd1000000000000000;
    localparam logic [MAG_W-1:0] SMALL_LIMIT = 50'd1000;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2e;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_MEGA  = 7'h4d;
    localparam logic [CHAR_W-1:0] CH_KILO  = 7'h6b;
    localparam logic [CHAR_W-1:0] CH_MICRO = 7'h75;
    localparam logic [CHAR_W-1:0] CH_LESS  = 7'h3c;
    localparam logic [CHAR_W-1:0] CH_MORE  = 7'h3e;

    // word carried down the conversion pipeline
    typedef struct packed {
        logic             zero;
        logic             huge;
        logic             small_val;
        logic [MAG_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } t_conv;

endpackage

// File: hw/rtl/four_char_si_number_formatter.sv
// Shows a signed number in millionths as four ASCII characters: "0.00" for zero,
// ">1MM" from 1e9 up, "<1uu" for negatives and values below 0.001, otherwise three
// truncated digits with 'k', 'M', '.' or a trailing space. One beat is taken every
// cycle while the output side is ready, and the pipeline never stalls on its own. A
// beat passes through one input stage for the range checks, then the binary to decimal
// conversion, which runs up to STEPS_PER_STAGE shift-add-3 steps per register stage
// over the 50 magnitude bits, and then one output stage.
module four_char_si_number_formatter #(
    parameter int STEPS_PER_STAGE = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [fcsnf_pkg::VALUE_W-1:0] i_value_micro,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_first,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_second,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_third,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_fourth
);
    import fcsnf_pkg::*;

    localparam int STAGE_N = (MAG_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    logic  r_valid;
    t_conv r_conv;
    t_conv n_conv;
    logic  en;

    logic  st_valid [STAGE_N+1];
    logic  st_ready [STAGE_N+1];
    t_conv st_data  [STAGE_N+1];

    assign en      = !r_valid || st_ready[0];
    assign o_ready = en;

    // range checks and magnitude capture
    always_comb begin
        n_conv           = '0;
        n_conv.bin       = i_value_micro[MAG_W-1:0];
        n_conv.zero      = (i_value_micro == '0);
        n_conv.huge      = !i_value_micro[MAG_W] && (i_value_micro[MAG_W-1:0] >= HUGE_LIMIT);
        n_conv.small_val = i_value_micro[MAG_W] || (i_value_micro[MAG_W-1:0] < SMALL_LIMIT);
    end

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_conv <= n_conv;
        end
    end

    assign st_valid[0] = r_valid;
    assign st_data[0]  = r_conv;

    // binary to bcd conversion stages
    for (genvar g = 0; g < STAGE_N; g++) begin : g_dabble
        localparam int STEPS = ((g + 1) * STEPS_PER_STAGE > MAG_W) ?
                               (MAG_W - g * STEPS_PER_STAGE) : STEPS_PER_STAGE;
        fcsnf_dabble_stage #(
            .STEPS (STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_data  (st_data[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_data  (st_data[g+1])
        );
    end

    // character selection and output register
    fcsnf_format_stage u_format (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (st_valid[STAGE_N]),
        .o_ready       (st_ready[STAGE_N]),
        .i_data        (st_data[STAGE_N]),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_char_first  (o_char_first),
        .o_char_second (o_char_second),
        .o_char_third  (o_char_third),
        .o_char_fourth (o_char_fourth)
    );

endmodule

// File: hw/rtl/fcsnf_dabble_stage.sv
module fcsnf_dabble_stage #(
    parameter int STEPS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fcsnf_pkg::t_conv i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output fcsnf_pkg::t_conv o_data
);
    import fcsnf_pkg::*;

    logic                   r_valid;
    t_conv                  r_data;
    t_conv                  n_data;
    logic [BCD_W+MAG_W-1:0] sh;
    logic                   en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // shift-add-3 steps, binary bits move into the bcd digits
    always_comb begin
        sh = {i_data.bcd, i_data.bin};
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < DIG_N; d++) begin
                if (sh[MAG_W + DIG_W*d +: DIG_W] >= 4'd5) begin
                    sh[MAG_W + DIG_W*d +: DIG_W] = sh[MAG_W + DIG_W*d +: DIG_W] + 4'd3;
                end
            end
            sh = sh << 1;
        end
        n_data     = i_data;
        n_data.bcd = sh[MAG_W +: BCD_W];
        n_data.bin = sh[MAG_W-1:0];
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: hw/rtl/fcsnf_format_stage.sv
module fcsnf_format_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fcsnf_pkg::t_conv            i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_first,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_second,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_third,
    output logic [fcsnf_pkg::CHAR_W-1:0] o_char_fourth
);
    import fcsnf_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_c0, r_c1, r_c2, r_c3;
    logic [CHAR_W-1:0] n_c0, n_c1, n_c2, n_c3;
    logic [CHAR_W-1:0] ch [DIG_N];
    logic              en;

    assign en            = !r_valid || i_ready;
    assign o_ready       = en;
    assign o_valid       = r_valid;
    assign o_char_first  = r_c0;
    assign o_char_second = r_c1;
    assign o_char_third  = r_c2;
    assign o_char_fourth = r_c3;

    // each bcd digit as an ascii character
    always_comb begin
        for (int d = 0; d < DIG_N; d++) begin
            ch[d] = CH_ZERO + {3'b000, i_data.bcd[DIG_W*d +: DIG_W]};
        end
    end

    // pick the form from the flags and the leading digit
    always_comb begin
        n_c0 = CH_POINT;
        n_c1 = ch[5];
        n_c2 = ch[4];
        n_c3 = ch[3];
        priority if (i_data.zero) begin
            n_c0 = CH_ZERO; n_c1 = CH_POINT; n_c2 = CH_ZERO; n_c3 = CH_ZERO;
        end else if (i_data.huge) begin
            n_c0 = CH_MORE; n_c1 = CH_ONE; n_c2 = CH_MEGA; n_c3 = CH_MEGA;
        end else if (i_data.small_val) begin
            n_c0 = CH_LESS; n_c1 = CH_ONE; n_c2 = CH_MICRO; n_c3 = CH_MICRO;
        end else if (ch[14] != CH_ZERO) begin
            n_c0 = ch[14]; n_c1 = ch[13]; n_c2 = ch[12]; n_c3 = CH_MEGA;
        end else if (ch[13] != CH_ZERO) begin
            n_c0 = ch[13]; n_c1 = ch[12]; n_c2 = CH_MEGA; n_c3 = ch[11];
        end else if (ch[12] != CH_ZERO) begin
            n_c0 = ch[12]; n_c1 = CH_MEGA; n_c2 = ch[11]; n_c3 = ch[10];
        end else if (ch[11] != CH_ZERO) begin
            n_c0 = ch[11]; n_c1 = ch[10]; n_c2 = ch[9]; n_c3 = CH_KILO;
        end else if (ch[10] != CH_ZERO) begin
            n_c0 = ch[10]; n_c1 = ch[9]; n_c2 = CH_KILO; n_c3 = ch[8];
        end else if (ch[9] != CH_ZERO) begin
            n_c0 = ch[9]; n_c1 = CH_KILO; n_c2 = ch[8]; n_c3 = ch[7];
        end else if (ch[8] != CH_ZERO) begin
            n_c0 = ch[8]; n_c1 = ch[7]; n_c2 = ch[6]; n_c3 = CH_SPACE;
        end else if (ch[7] != CH_ZERO) begin
            n_c0 = ch[7]; n_c1 = ch[6]; n_c2 = CH_POINT; n_c3 = ch[5];
        end else if (ch[6] != CH_ZERO) begin
            n_c0 = ch[6]; n_c1 = CH_POINT; n_c2 = ch[5]; n_c3 = ch[4];
        end else begin
            n_c0 = CH_POINT; n_c1 = ch[5]; n_c2 = ch[4]; n_c3 = ch[3];
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    // output characters
    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_c0 <= n_c0;
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= n_c3;
        end
    end

endmodule
